// ----- rtl/core/pheromone_table_engine_top_defines.svh -----
// Assertion macros for the pheromone table engine.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef PHEROMONE_TABLE_ENGINE_TOP_DEFINES_SVH
`define PHEROMONE_TABLE_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define PTE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pheromone table engine check failed");
// Checked at every edge, reset included.
`define PTE_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pheromone table engine reset check failed");
`else
`define PTE_ASSERT(label, prop)
`define PTE_ASSERT_RST(label, prop)
`endif

`endif

// ----- rtl/core/pte_pkg.sv -----
// Package for the pheromone table engine: widths, codes, state type.
// No dependencies; used by the interfaces, the RAM wrapper's user and the top level.
`timescale 1ns / 1ps

package pte_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CELLS     = MAX_NODES * MAX_NODES;
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32 + FRAC_BITS;
    localparam int RHO_W     = 16;
    localparam int TSIZE_W   = 7;
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 6;

    localparam int CFG_W     = VAL_W;
    localparam int CFG_IDX_W = 2;

    // Divider sizes: dividend is the cost operand scaled by the rho fraction width.
    localparam int DIV_W     = VAL_W + RHO_W;
    localparam int DIVISOR_W = RHO_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Evaporation product of an entry and the kept fraction.
    localparam int EVAP_PROD_W = VAL_W + RHO_W + 1;

    localparam logic [VAL_W-1:0] INIT_VALUE = VAL_W'(64'd10000000 << FRAC_BITS);
    localparam logic [RHO_W:0]   RHO_ONE    = (RHO_W + 1)'(1) << RHO_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RHO     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOSIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TSIZE   = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ    = 3'd0,
        FUNC_DEP_DEF = 3'd1,
        FUNC_DEP_VAL = 3'd2,
        FUNC_EVAP    = 3'd3,
        FUNC_CLAMP   = 3'd4,
        FUNC_REFILL  = 3'd5
    } func_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_ACCESS,
        ST_MIRROR,
        ST_DIV1,
        ST_DIV2,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/pte_cmd_if.sv -----
// Command channel of the pheromone table engine: one operation per word.
// Depends on pte_pkg for the field widths.
`timescale 1ns / 1ps

interface pte_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [pte_pkg::FUNC_W-1:0]  func;
    logic [pte_pkg::IDX_W-1:0]   row;
    logic [pte_pkg::IDX_W-1:0]   col;
    logic [pte_pkg::VAL_W-1:0]   operand;

    modport source (output valid, output func, output row, output col, output operand,
                    input ready);
    modport sink   (input valid, input func, input row, input col, input operand,
                    output ready);
endinterface

// ----- rtl/core/pte_rsp_if.sv -----
// Response channel of the pheromone table engine: one result word per command.
// Depends on pte_pkg for the field widths.
`timescale 1ns / 1ps

interface pte_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pte_pkg::VAL_W-1:0]  entry_value;
    logic                       skipped;

    modport source (output valid, output entry_value, output skipped, input ready);
    modport sink   (input valid, input entry_value, input skipped, output ready);
endinterface

// ----- rtl/core/pheromone_table_engine_top.sv -----
// Pheromone table engine top level: sequencer, shared divider and table RAM.
// Depends on pte_pkg, pte_cmd_if, pte_rsp_if, pte_ram and the defines header.
//
// The table of MAX_NODES*MAX_NODES Q32.16 entries lives in one RAM with a
// registered read, and every command yields exactly one response word. One
// command is worked on at a time; the response register lets the next
// command in while the last word still waits. A read reads the entry; a
// deposit reads, writes and then makes the mirror write. Evaporate walks the
// n*n live entries at one entry per cycle; clamp, unless skipped, first runs
// the bit serial divider twice (DIV_W = 64) for max and min, then walks the
// same way. Refill rewrites the whole table through the single write port.
// After reset the engine fills all CELLS (4096) entries, during which no
// command is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`include "pheromone_table_engine_top_defines.svh"

module pheromone_table_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    pte_cmd_if.sink                         cmd,
    pte_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pte_pkg::CFG_W-1:0]       cfg_data
);

    // Control state
    pte_pkg::state_t                  state_reg, state_next;
    pte_pkg::func_t                   op_reg, op_next;
    logic [pte_pkg::ADDR_W-1:0]       fill_addr_reg, fill_addr_next;
    logic                             fill_res_reg, fill_res_next;
    logic [pte_pkg::NODE_W-1:0]       i_reg, i_next;
    logic [pte_pkg::NODE_W-1:0]       j_reg, j_next;
    logic                             wr_pend_reg, wr_pend_next;
    logic [pte_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic [pte_pkg::RHO_W-1:0]        rho_reg, rho_next;
    logic [pte_pkg::VAL_W-1:0]        deposit_amount_reg, deposit_amount_next;
    logic [pte_pkg::TSIZE_W-1:0]      table_size_reg, table_size_next;

    // Payload
    logic [pte_pkg::ADDR_W-1:0]       addr_a_reg, addr_a_next;
    logic [pte_pkg::ADDR_W-1:0]       addr_b_reg, addr_b_next;
    logic [pte_pkg::VAL_W-1:0]        add_reg, add_next;
    logic [pte_pkg::VAL_W-1:0]        res_value_reg, res_value_next;
    logic                             res_skip_reg, res_skip_next;
    logic [pte_pkg::ADDR_W-1:0]       wr_addr_reg, wr_addr_next;
    logic [pte_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [pte_pkg::DIV_W-1:0]        quo_reg, quo_next;
    logic [pte_pkg::DIVISOR_W-1:0]    dvs_reg, dvs_next;
    logic [pte_pkg::VAL_W-1:0]        max_reg, max_next;
    logic [pte_pkg::VAL_W-1:0]        min_reg, min_next;
    logic [pte_pkg::VAL_W-1:0]        out_value_reg, out_value_next;
    logic                             out_skip_reg, out_skip_next;

    // RAM port
    logic                             ram_we;
    logic [pte_pkg::ADDR_W-1:0]       ram_waddr;
    logic [pte_pkg::VAL_W-1:0]        ram_wdata;
    logic                             ram_re;
    logic [pte_pkg::ADDR_W-1:0]       ram_raddr;
    logic [pte_pkg::VAL_W-1:0]        ram_rdata;

    // Datapath
    logic [pte_pkg::NCNT_W-1:0]       n_eff;
    logic [pte_pkg::NODE_W-1:0]       n_last;
    logic                             walk_last;
    logic                             cmd_in_range;
    logic [pte_pkg::DIVISOR_W:0]      div_trial;
    logic                             div_ge;
    logic [pte_pkg::DIVISOR_W-1:0]    rem_step;
    logic [pte_pkg::DIV_W-1:0]        quo_step;
    logic [pte_pkg::VAL_W-1:0]        quo_sat;
    logic [pte_pkg::RHO_W:0]          keep_frac;
    logic [pte_pkg::EVAP_PROD_W-1:0]  evap_prod;
    logic [pte_pkg::VAL_W-1:0]        evap_val;
    logic [pte_pkg::VAL_W-1:0]        clamp_hi;
    logic [pte_pkg::VAL_W-1:0]        clamp_val;
    logic [pte_pkg::VAL_W-1:0]        walk_wdata;
    logic [pte_pkg::VAL_W:0]          dep_sum;
    logic [pte_pkg::VAL_W-1:0]        dep_val;

    pte_ram #(
        .WIDTH (pte_pkg::VAL_W),
        .DEPTH (pte_pkg::CELLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A table size of zero acts as one node, anything above the store as the store.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_eff = pte_pkg::NCNT_W'(1);
        end
        else if (int'(table_size_reg) > pte_pkg::MAX_NODES)
        begin
            n_eff = pte_pkg::NCNT_W'(pte_pkg::MAX_NODES);
        end
        else
        begin
            n_eff = pte_pkg::NCNT_W'(table_size_reg);
        end
    end

    assign n_last       = pte_pkg::NODE_W'(n_eff - pte_pkg::NCNT_W'(1));
    assign walk_last    = (i_reg == n_last) && (j_reg == n_last);
    assign cmd_in_range = (int'(cmd.row) < int'(n_eff)) && (int'(cmd.col) < int'(n_eff));

    // One restoring division step per cycle.
    assign div_trial = {rem_reg, quo_reg[pte_pkg::DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});
    assign rem_step  = div_ge ? pte_pkg::DIVISOR_W'(div_trial - {1'b0, dvs_reg})
                              : pte_pkg::DIVISOR_W'(div_trial);
    assign quo_step  = {quo_reg[pte_pkg::DIV_W-2:0], div_ge};
    assign quo_sat   = (quo_step[pte_pkg::DIV_W-1:pte_pkg::VAL_W] != '0)
                       ? '1 : quo_step[pte_pkg::VAL_W-1:0];

    // Evaporation keeps the fraction (1 - rho); the product is exact before the shift.
    assign keep_frac = pte_pkg::RHO_ONE - {1'b0, rho_reg};
    assign evap_prod = pte_pkg::EVAP_PROD_W'(ram_rdata) * pte_pkg::EVAP_PROD_W'(keep_frac);
    assign evap_val  = evap_prod[pte_pkg::RHO_W +: pte_pkg::VAL_W];

    assign clamp_hi   = (ram_rdata > max_reg) ? max_reg : ram_rdata;
    assign clamp_val  = (clamp_hi < min_reg) ? min_reg : clamp_hi;
    assign walk_wdata = (op_reg == pte_pkg::FUNC_EVAP) ? evap_val : clamp_val;

    assign dep_sum = {1'b0, ram_rdata} + {1'b0, add_reg};
    assign dep_val = dep_sum[pte_pkg::VAL_W] ? '1 : dep_sum[pte_pkg::VAL_W-1:0];

    assign cmd.ready       = (state_reg == pte_pkg::ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.skipped     = out_skip_reg;

    always_comb
    begin
        state_next          = state_reg;
        op_next             = op_reg;
        fill_addr_next      = fill_addr_reg;
        fill_res_next       = fill_res_reg;
        i_next              = i_reg;
        j_next              = j_reg;
        wr_pend_next        = wr_pend_reg;
        div_cnt_next        = div_cnt_reg;
        out_valid_next      = out_valid_reg;
        rho_next            = rho_reg;
        deposit_amount_next = deposit_amount_reg;
        table_size_next     = table_size_reg;
        addr_a_next         = addr_a_reg;
        addr_b_next         = addr_b_reg;
        add_next            = add_reg;
        res_value_next      = res_value_reg;
        res_skip_next       = res_skip_reg;
        wr_addr_next        = wr_addr_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        dvs_next            = dvs_reg;
        max_next            = max_reg;
        min_next            = min_reg;
        out_value_next      = out_value_reg;
        out_skip_next       = out_skip_reg;

        ram_we    = 1'b0;
        ram_waddr = fill_addr_reg;
        ram_wdata = pte_pkg::INIT_VALUE;
        ram_re    = 1'b0;
        ram_raddr = {i_reg, j_reg};

        if (cfg_we)
        begin
            unique case (cfg_index)
                pte_pkg::CFG_RHO:     rho_next = cfg_data[pte_pkg::RHO_W-1:0];
                pte_pkg::CFG_DEPOSIT: deposit_amount_next = cfg_data[pte_pkg::VAL_W-1:0];
                pte_pkg::CFG_TSIZE:   table_size_next = cfg_data[pte_pkg::TSIZE_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pte_pkg::ST_FILL:
            begin
                ram_we         = 1'b1;
                fill_addr_next = fill_addr_reg + pte_pkg::ADDR_W'(1);
                if (fill_addr_reg == pte_pkg::ADDR_W'(pte_pkg::CELLS - 1))
                begin
                    // The fill after reset gives no response word; a refill does.
                    state_next    = fill_res_reg ? pte_pkg::ST_DONE : pte_pkg::ST_IDLE;
                    fill_res_next = 1'b0;
                end
            end

            pte_pkg::ST_IDLE:
            begin
                ram_raddr = {pte_pkg::NODE_W'(cmd.row), pte_pkg::NODE_W'(cmd.col)};
                if (cmd.valid)
                begin
                    ram_re         = 1'b1;
                    op_next        = pte_pkg::func_t'(cmd.func);
                    addr_a_next    = {pte_pkg::NODE_W'(cmd.row), pte_pkg::NODE_W'(cmd.col)};
                    addr_b_next    = {pte_pkg::NODE_W'(cmd.col), pte_pkg::NODE_W'(cmd.row)};
                    add_next       = (pte_pkg::func_t'(cmd.func) == pte_pkg::FUNC_DEP_DEF)
                                     ? deposit_amount_reg : cmd.operand;
                    res_value_next = '0;
                    res_skip_next  = 1'b0;
                    unique case (pte_pkg::func_t'(cmd.func))
                        pte_pkg::FUNC_READ,
                        pte_pkg::FUNC_DEP_DEF,
                        pte_pkg::FUNC_DEP_VAL:
                        begin
                            state_next = cmd_in_range ? pte_pkg::ST_ACCESS : pte_pkg::ST_DONE;
                        end
                        pte_pkg::FUNC_EVAP:
                        begin
                            i_next       = '0;
                            j_next       = '0;
                            wr_pend_next = 1'b0;
                            state_next   = pte_pkg::ST_WALK;
                        end
                        pte_pkg::FUNC_CLAMP:
                        begin
                            if ((cmd.operand == '0) || (rho_reg == '0))
                            begin
                                res_skip_next = 1'b1;
                                state_next    = pte_pkg::ST_DONE;
                            end
                            else
                            begin
                                rem_next     = '0;
                                quo_next     = {cmd.operand, {pte_pkg::RHO_W{1'b0}}};
                                dvs_next     = rho_reg;
                                div_cnt_next = '0;
                                state_next   = pte_pkg::ST_DIV1;
                            end
                        end
                        pte_pkg::FUNC_REFILL:
                        begin
                            fill_addr_next = '0;
                            fill_res_next  = 1'b1;
                            state_next     = pte_pkg::ST_FILL;
                        end
                        default:
                        begin
                            state_next = pte_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            pte_pkg::ST_ACCESS:
            begin
                if (op_reg == pte_pkg::FUNC_READ)
                begin
                    res_value_next = ram_rdata;
                    state_next     = pte_pkg::ST_DONE;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = addr_a_reg;
                    ram_wdata      = dep_val;
                    res_value_next = dep_val;
                    state_next     = pte_pkg::ST_MIRROR;
                end
            end

            pte_pkg::ST_MIRROR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_b_reg;
                ram_wdata  = res_value_reg;
                state_next = pte_pkg::ST_DONE;
            end

            pte_pkg::ST_DIV1:
            begin
                rem_next     = rem_step;
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg + pte_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == pte_pkg::DIV_CNT_W'(pte_pkg::DIV_W - 1))
                begin
                    // Upper bound is ready; divide it by 2n for the lower bound.
                    max_next     = quo_sat;
                    rem_next     = '0;
                    quo_next     = {{pte_pkg::RHO_W{1'b0}}, quo_sat};
                    dvs_next     = pte_pkg::DIVISOR_W'({n_eff, 1'b0});
                    div_cnt_next = '0;
                    state_next   = pte_pkg::ST_DIV2;
                end
            end

            pte_pkg::ST_DIV2:
            begin
                rem_next     = rem_step;
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg + pte_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == pte_pkg::DIV_CNT_W'(pte_pkg::DIV_W - 1))
                begin
                    min_next     = quo_step[pte_pkg::VAL_W-1:0];
                    i_next       = '0;
                    j_next       = '0;
                    wr_pend_next = 1'b0;
                    state_next   = pte_pkg::ST_WALK;
                end
            end

            pte_pkg::ST_WALK:
            begin
                // Read the next entry while writing back the one read in the cycle before.
                ram_re       = 1'b1;
                ram_raddr    = {i_reg, j_reg};
                wr_pend_next = 1'b1;
                wr_addr_next = {i_reg, j_reg};
                if (wr_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = walk_wdata;
                end
                if (j_reg == n_last)
                begin
                    j_next = '0;
                    i_next = i_reg + pte_pkg::NODE_W'(1);
                end
                else
                begin
                    j_next = j_reg + pte_pkg::NODE_W'(1);
                end
                if (walk_last)
                begin
                    state_next = pte_pkg::ST_DRAIN;
                end
            end

            pte_pkg::ST_DRAIN:
            begin
                ram_we       = 1'b1;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = walk_wdata;
                wr_pend_next = 1'b0;
                state_next   = pte_pkg::ST_DONE;
            end

            pte_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_skip_next  = res_skip_reg;
                    state_next     = pte_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pte_pkg::ST_FILL;
            op_reg             <= pte_pkg::FUNC_READ;
            fill_addr_reg      <= '0;
            fill_res_reg       <= 1'b0;
            i_reg              <= '0;
            j_reg              <= '0;
            wr_pend_reg        <= 1'b0;
            div_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
            rho_reg            <= pte_pkg::RHO_W'(1311);
            deposit_amount_reg <= pte_pkg::VAL_W'(65536);
            table_size_reg     <= pte_pkg::TSIZE_W'(64);
        end
        else
        begin
            state_reg          <= state_next;
            op_reg             <= op_next;
            fill_addr_reg      <= fill_addr_next;
            fill_res_reg       <= fill_res_next;
            i_reg              <= i_next;
            j_reg              <= j_next;
            wr_pend_reg        <= wr_pend_next;
            div_cnt_reg        <= div_cnt_next;
            out_valid_reg      <= out_valid_next;
            rho_reg            <= rho_next;
            deposit_amount_reg <= deposit_amount_next;
            table_size_reg     <= table_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_a_reg    <= addr_a_next;
        addr_b_reg    <= addr_b_next;
        add_reg       <= add_next;
        res_value_reg <= res_value_next;
        res_skip_reg  <= res_skip_next;
        wr_addr_reg   <= wr_addr_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        max_reg       <= max_next;
        min_reg       <= min_next;
        out_value_reg <= out_value_next;
        out_skip_reg  <= out_skip_next;
    end

    // The walk never writes the entry it is reading in the same cycle.
    `PTE_ASSERT(a_no_rw_collision, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    // The clamp bounds are ordered before the walk uses them.
    `PTE_ASSERT(a_clamp_bounds,
        ((state_reg == pte_pkg::ST_WALK) && (op_reg == pte_pkg::FUNC_CLAMP)) |-> (min_reg <= max_reg))
    // A response word appears only when a command has finished.
    `PTE_ASSERT(a_rsp_from_done, $rose(out_valid_reg) |-> ($past(state_reg) == pte_pkg::ST_DONE))
    // Nothing is offered or taken while reset is held.
    `PTE_ASSERT_RST(a_reset_quiet, !rst_n |-> (!cmd.ready && !rsp.valid))

endmodule

// ----- rtl/core/pte_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pte_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- dv/pheromone_table_engine_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the pheromone table engine top level.
// Depends on pte_pkg, pte_cmd_if, pte_rsp_if and pheromone_table_engine_top; every response
// word is predicted from a shadow copy of the pheromone table and the registers.

module pheromone_table_engine_top_tb;

    // Command codes the engine must ignore.
    localparam logic [pte_pkg::FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
    localparam logic [pte_pkg::FUNC_W-1:0] FUNC_RSVD_B = 3'd7;

    localparam logic [pte_pkg::RHO_W-1:0]   RHO_AT_RESET     = 16'd1311;
    localparam logic [pte_pkg::VAL_W-1:0]   DEPOSIT_AT_RESET = 48'd65536;
    localparam logic [pte_pkg::TSIZE_W-1:0] TSIZE_AT_RESET   = 7'd64;

    localparam logic [pte_pkg::VAL_W-1:0] VAL_MAX       = '1;
    localparam logic [pte_pkg::VAL_W-1:0] COST_256      = 48'h0000_0100_0000;
    localparam logic [pte_pkg::VAL_W-1:0] COST_ONE      = 48'h0000_0001_0000;
    localparam int                        STALL_LIMIT   = 20000;
    localparam int                        SETTLE_CYCLES = 20;
    localparam int                        RANDOM_PHASES = 6;
    localparam int                        PHASE_WORDS   = 20;

    typedef struct packed {
        logic [pte_pkg::VAL_W-1:0] entry_value;
        logic                      skipped;
    } rsp_word_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PULSED, RX_HOLD} rx_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pte_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pte_pkg::CFG_W-1:0]     cfg_data;

    pte_cmd_if cmd_ch ();
    pte_rsp_if rsp_ch ();

    pheromone_table_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the engine state.
    logic [pte_pkg::VAL_W-1:0]   trail_shadow [pte_pkg::CELLS];
    logic [pte_pkg::RHO_W-1:0]   rho_reg;
    logic [pte_pkg::VAL_W-1:0]   deposit_reg;
    logic [pte_pkg::TSIZE_W-1:0] tsize_reg;

    rsp_word_t due_words [$];
    int        fault_count  = 0;
    int        quiet_cycles = 0;
    int        burst_left   = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned live_nodes();
        if (tsize_reg == 0)
            return 1;
        if (tsize_reg > pte_pkg::MAX_NODES)
            return pte_pkg::MAX_NODES;
        return 32'(tsize_reg);
    endfunction

    function automatic void refill_shadow();
        for (int k = 0; k < pte_pkg::CELLS; k++)
            trail_shadow[k] = pte_pkg::INIT_VALUE;
    endfunction

    // Applies one command to the shadow table and returns the word it should produce.
    function automatic rsp_word_t apply_operation(input logic [pte_pkg::FUNC_W-1:0] fcode,
                                                  input logic [pte_pkg::IDX_W-1:0]  r,
                                                  input logic [pte_pkg::IDX_W-1:0]  c,
                                                  input logic [pte_pkg::VAL_W-1:0]  opnd);
        rsp_word_t                              res;
        int unsigned                            n;
        int unsigned                            fwd;
        int unsigned                            back;
        int unsigned                            slot;
        logic [pte_pkg::VAL_W-1:0]              addend;
        logic [pte_pkg::VAL_W:0]                sum;
        logic [pte_pkg::RHO_W:0]                keep;
        logic [pte_pkg::VAL_W+pte_pkg::RHO_W:0] scaled;
        logic [pte_pkg::DIV_W-1:0]              ceil_q;
        logic [pte_pkg::DIV_W-1:0]              floor_q;
        res = '0;
        n = live_nodes();
        case (fcode)
            pte_pkg::FUNC_READ, pte_pkg::FUNC_DEP_DEF, pte_pkg::FUNC_DEP_VAL:
            begin
                if (r < n && c < n)
                begin
                    fwd  = r * pte_pkg::MAX_NODES + c;
                    back = c * pte_pkg::MAX_NODES + r;
                    if (fcode == pte_pkg::FUNC_READ)
                        res.entry_value = trail_shadow[fwd];
                    else
                    begin
                        addend = (fcode == pte_pkg::FUNC_DEP_DEF) ? deposit_reg : opnd;
                        sum = {1'b0, trail_shadow[fwd]} + {1'b0, addend};
                        trail_shadow[fwd]  = sum[pte_pkg::VAL_W] ? VAL_MAX
                                                                 : sum[pte_pkg::VAL_W-1:0];
                        trail_shadow[back] = trail_shadow[fwd];
                        res.entry_value    = trail_shadow[fwd];
                    end
                end
            end
            pte_pkg::FUNC_EVAP:
            begin
                keep = pte_pkg::RHO_ONE - {1'b0, rho_reg};
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                    begin
                        slot = i * pte_pkg::MAX_NODES + j;
                        scaled = trail_shadow[slot] * keep;
                        trail_shadow[slot] =
                            scaled[pte_pkg::VAL_W+pte_pkg::RHO_W-1:pte_pkg::RHO_W];
                    end
            end
            pte_pkg::FUNC_CLAMP:
            begin
                if (opnd == 0 || rho_reg == 0)
                    res.skipped = 1'b1;
                else
                begin
                    ceil_q = {opnd, {pte_pkg::RHO_W{1'b0}}} / rho_reg;
                    if (ceil_q > VAL_MAX)
                        ceil_q = VAL_MAX;
                    floor_q = ceil_q / (2 * n);
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                        begin
                            slot = i * pte_pkg::MAX_NODES + j;
                            if (trail_shadow[slot] > ceil_q)
                                trail_shadow[slot] = ceil_q[pte_pkg::VAL_W-1:0];
                            if (trail_shadow[slot] < floor_q)
                                trail_shadow[slot] = floor_q[pte_pkg::VAL_W-1:0];
                        end
                end
            end
            pte_pkg::FUNC_REFILL:
                refill_shadow();
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic logic [pte_pkg::VAL_W-1:0] rand_operand();
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom(), $urandom()};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return VAL_MAX;
        // A random shift spreads values over every magnitude of the Q32.16 range.
        return raw[pte_pkg::VAL_W-1:0] >> $urandom_range(0, pte_pkg::VAL_W - 1);
    endfunction

    function automatic logic [pte_pkg::IDX_W-1:0] pick_node(input int unsigned n);
        if ($urandom_range(0, 4) != 0)
            return pte_pkg::IDX_W'($urandom_range(0, n - 1));
        return pte_pkg::IDX_W'($urandom_range(0, pte_pkg::MAX_NODES - 1));
    endfunction

    // Sends one command word in bursts; valid stays high between words of a burst.
    task automatic send_word(input logic [pte_pkg::FUNC_W-1:0] fcode,
                             input logic [pte_pkg::IDX_W-1:0] r,
                             input logic [pte_pkg::IDX_W-1:0] c,
                             input logic [pte_pkg::VAL_W-1:0] opnd);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= fcode;
        cmd_ch.row     <= r;
        cmd_ch.col     <= c;
        cmd_ch.operand <= opnd;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        due_words.push_back(apply_operation(fcode, r, c, opnd));
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (due_words.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_registers(input logic [pte_pkg::RHO_W-1:0]   rho_v,
                                   input logic [pte_pkg::VAL_W-1:0]   dep_v,
                                   input logic [pte_pkg::TSIZE_W-1:0] size_v);
        cfg_we    <= 1'b1;
        cfg_index <= pte_pkg::CFG_RHO;
        cfg_data  <= pte_pkg::CFG_W'(rho_v);
        @(posedge clk);
        cfg_index <= pte_pkg::CFG_DEPOSIT;
        cfg_data  <= dep_v;
        @(posedge clk);
        cfg_index <= pte_pkg::CFG_TSIZE;
        cfg_data  <= pte_pkg::CFG_W'(size_v);
        @(posedge clk);
        cfg_we <= 1'b0;
        rho_reg     = rho_v;
        deposit_reg = dep_v;
        tsize_reg   = size_v;
    endtask

    task automatic test_access_and_mirror();
        send_word(pte_pkg::FUNC_READ, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd63, 6'd63, VAL_MAX);
        send_word(pte_pkg::FUNC_DEP_DEF, 6'd0, 6'd63, '0);
        send_word(pte_pkg::FUNC_READ, 6'd63, 6'd0, '0);
        send_word(pte_pkg::FUNC_DEP_VAL, 6'd5, 6'd7, VAL_MAX);
        send_word(pte_pkg::FUNC_READ, 6'd7, 6'd5, '0);
    endtask

    task automatic test_bulk_operations();
        send_word(pte_pkg::FUNC_EVAP, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd5, 6'd7, '0);
        send_word(pte_pkg::FUNC_CLAMP, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_CLAMP, 6'd0, 6'd0, COST_256);
        send_word(pte_pkg::FUNC_READ, 6'd0, 6'd63, '0);
        send_word(FUNC_RSVD_A, 6'd63, 6'd63, VAL_MAX);
        send_word(FUNC_RSVD_B, 6'd1, 6'd2, rand_operand());
        send_word(pte_pkg::FUNC_REFILL, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd63, 6'd0, '0);
    endtask

    task automatic test_register_extremes();
        // A size of zero acts as one node, and zero rho makes clamp a no-op.
        wait_drained();
        write_registers('0, VAL_MAX, '0);
        send_word(pte_pkg::FUNC_CLAMP, 6'd0, 6'd0, COST_ONE);
        send_word(pte_pkg::FUNC_EVAP, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd1, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd0, 6'd5, '0);
        send_word(pte_pkg::FUNC_DEP_DEF, 6'd0, 6'd1, '0);
        send_word(pte_pkg::FUNC_DEP_DEF, 6'd0, 6'd0, '0);
        // Sizes above the table act as the full table.
        wait_drained();
        write_registers('1, '0, '1);
        send_word(pte_pkg::FUNC_EVAP, 6'd0, 6'd0, '0);
        send_word(pte_pkg::FUNC_READ, 6'd63, 6'd62, '0);
        send_word(pte_pkg::FUNC_DEP_DEF, 6'd2, 6'd3, '0);
        send_word(pte_pkg::FUNC_REFILL, 6'd0, 6'd0, '0);
    endtask

    task automatic test_random_traffic();
        int                          pick;
        int unsigned                 n;
        logic [pte_pkg::RHO_W-1:0]   rho_v;
        logic [pte_pkg::TSIZE_W-1:0] size_v;
        logic [pte_pkg::FUNC_W-1:0]  fcode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            // Mostly small tables keep the bulk walks short.
            pick = $urandom_range(0, 19);
            if (pick <= 10)
                size_v = pte_pkg::TSIZE_W'($urandom_range(1, 8));
            else if (pick <= 13)
                size_v = pte_pkg::TSIZE_W'($urandom_range(9, 63));
            else if (pick <= 15)
                size_v = pte_pkg::TSIZE_W'(pte_pkg::MAX_NODES);
            else if (pick == 16)
                size_v = '0;
            else
                size_v = pte_pkg::TSIZE_W'($urandom_range(65, 127));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rho_v = '0;
            else if (pick == 1)
                rho_v = '1;
            else
                rho_v = pte_pkg::RHO_W'($urandom_range(1, 65534));
            write_registers(rho_v, rand_operand(), size_v);
            n = live_nodes();
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (phase == 2 && k == PHASE_WORDS / 2)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 28)
                    fcode = pte_pkg::FUNC_READ;
                else if (pick < 48)
                    fcode = pte_pkg::FUNC_DEP_DEF;
                else if (pick < 73)
                    fcode = pte_pkg::FUNC_DEP_VAL;
                else if (pick < 82)
                    fcode = pte_pkg::FUNC_EVAP;
                else if (pick < 91)
                    fcode = pte_pkg::FUNC_CLAMP;
                else if (pick < 94)
                    fcode = pte_pkg::FUNC_REFILL;
                else if (pick < 97)
                    fcode = FUNC_RSVD_A;
                else
                    fcode = FUNC_RSVD_B;
                send_word(fcode, pick_node(n), pick_node(n), rand_operand());
            end
        end
    endtask

    // The receiver switches between open, random, pulsed and held-off stretches.
    initial
    begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = (mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(10, 60);
            end
            left--;
            case (mode)
                RX_OPEN:   rsp_ch.ready <= 1'b1;
                RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
                RX_PULSED: rsp_ch.ready <= (left % 4) != 0;
                default:   rsp_ch.ready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_words.size() == 0)
            begin
                $error("response word with no command outstanding: entry_value %h",
                       rsp_ch.entry_value);
                fault_count++;
            end
            else
            begin
                want = due_words.pop_front();
                if (rsp_ch.entry_value !== want.entry_value)
                begin
                    $error("entry_value mismatch: expected %h, got %h",
                           want.entry_value, rsp_ch.entry_value);
                    fault_count++;
                end
                if (rsp_ch.skipped !== want.skipped)
                begin
                    $error("skipped mismatch: expected %b, got %b", want.skipped, rsp_ch.skipped);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= pte_pkg::FUNC_READ;
        cmd_ch.row     <= '0;
        cmd_ch.col     <= '0;
        cmd_ch.operand <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= pte_pkg::CFG_RHO;
        cfg_data       <= '0;
        rho_reg     = RHO_AT_RESET;
        deposit_reg = DEPOSIT_AT_RESET;
        tsize_reg   = TSIZE_AT_RESET;
        refill_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // The first command waits out the filling pass behind ready.
        test_access_and_mirror();
        test_bulk_operations();
        test_register_extremes();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pte_pkg.sv
rtl/core/pte_cmd_if.sv
rtl/core/pte_rsp_if.sv
rtl/core/pte_ram.sv
rtl/core/pheromone_table_engine_top.sv
dv/pheromone_table_engine_top_tb.sv
